// ----- sv/bmd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmd_pkg: shared definitions for the binary mask dilation core
// Field widths, size limits, configuration register codes and the layout of
// one entry of the column hit memory.
// ----------------------------------------------------------------------------
`default_nettype none

package bmd_pkg;

    // Size limits of the design
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 15;

    // Fixed widths of the configuration and payload fields
    localparam int FW_W   = 11;
    localparam int FH_W   = 16;
    localparam int RAD_W  = 4;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // Derived widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WC_W  = FW_W + 1;
    localparam int ROW_W = FH_W + 1;
    localparam int WIN_W = 2 * MAX_RADIUS + 1;
    localparam int LAG_W = RAD_W + FW_W;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RADIUS       = 2'd2;

    // Reset values of the configuration registers
    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 16'd1024;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 4'd1;

    // One column entry: whether a hit has been seen in this frame, and the
    // last row whose horizontal window around the column held a seed
    typedef struct packed {
        logic            hit;
        logic [FH_W-1:0] row;
    } gap_entry_t;

    localparam int ENTRY_W = $bits(gap_entry_t);

endpackage

`default_nettype wire

// ----- sv/binary_mask_dilation_core.sv -----
// ----------------------------------------------------------------------------
// binary_mask_dilation_core: streaming square dilation of a binary mask
// Accepts one mask pixel per clock in raster order and returns dilated pixels
// radius rows plus radius pixels behind the input, using one column memory.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while results are taken, with no bubbles
// between frames. The pixel transaction that causes a result reads the column
// memory into the read stage; the result register then takes the result.
// Reset: frame_width 1024, frame_height 1024, radius 1, block idle. The column
// memory is not cleared; when any pixel of the frame can be a seed, the first
// row of each frame writes every column before any output reads it.
`default_nettype none

module binary_mask_dilation_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Pixel channel
    input  wire logic                         pixel_valid,
    output logic                              pixel_ready,
    input  wire logic [bmd_pkg::BYTE_W-1:0]   mask_byte,
    input  wire logic                         is_flush,
    // Result channel
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic                              dilated_bit,
    output logic                              frame_last,
    // Configuration channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bmd_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [bmd_pkg::CFG_W-1:0]    cfg_data
);

    localparam int FW_W  = bmd_pkg::FW_W;
    localparam int FH_W  = bmd_pkg::FH_W;
    localparam int RAD_W = bmd_pkg::RAD_W;
    localparam int COL_W = bmd_pkg::COL_W;
    localparam int WC_W  = bmd_pkg::WC_W;
    localparam int ROW_W = bmd_pkg::ROW_W;
    localparam int WIN_W = bmd_pkg::WIN_W;
    localparam int LAG_W = bmd_pkg::LAG_W;

    // Configuration registers
    logic [FW_W-1:0]  fw_reg,  fw_next;
    logic [FH_W-1:0]  fh_reg,  fh_next;
    logic [RAD_W-1:0] rad_reg, rad_next;

    // Frame position and row window
    logic             start_reg,   start_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [FH_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [LAG_W-1:0] lead_reg,    lead_next;
    logic [WIN_W-1:0] win_reg,     win_next;

    // Read stage and result register
    logic                s1_valid_reg, s1_valid_next;
    logic [FH_W-1:0]     s1_orow_reg;
    logic                s1_last_reg;
    logic                s1_fwd_reg;
    bmd_pkg::gap_entry_t s1_fwd_data_reg;
    logic                result_valid_reg, result_valid_next;
    logic                dilated_bit_reg;
    logic                frame_last_reg;

    // Effective configuration
    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [RAD_W-1:0] r_eff;
    logic [LAG_W-1:0] lag;
    logic             seeds_ok;

    // Per-pixel decode
    logic                 pixel_fire;
    logic                 cfg_fire;
    logic                 res_advance;
    logic                 s1_go;
    logic                 tail;
    logic                 frame_begin;
    logic                 skip;
    logic [ROW_W-1:0]     cur_row;
    logic [COL_W-1:0]     cur_col;
    logic [WIN_W-1:0]     cur_win;
    logic [LAG_W-1:0]     cur_lead;
    logic [FH_W-1:0]      cur_orow;
    logic [COL_W-1:0]     cur_ocol;
    logic [WC_W-1:0]      jx;
    logic [WC_W-1:0]      rx;
    logic [WC_W-1:0]      wx;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     h_row;
    logic                 col_ge_r;
    logic                 seed;
    logic [WIN_W-1:0]     win_new;
    logic [WIN_W-1:0]     win_mask;
    logic                 hit;
    logic [ROW_W-1:0]     note_row;
    logic                 note_en;
    logic [COL_W-1:0]     wr_col;
    logic                 wr_en;
    bmd_pkg::gap_entry_t  wr_entry;
    logic                 emit;
    logic                 ocol_end;
    logic                 orow_end;
    logic                 last;
    logic                 col_end;
    logic                 fwd;

    // Read stage decode
    logic [bmd_pkg::ENTRY_W-1:0] rd_data;
    bmd_pkg::gap_entry_t         rd_entry;
    bmd_pkg::gap_entry_t         s1_entry;
    logic                        s1_bit;

    // Clamp configuration to the supported range
    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (int'(fw_reg) > bmd_pkg::MAX_WIDTH)
        begin
            w_eff = FW_W'(bmd_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_reg;
        end
        h_eff = (fh_reg == '0) ? FH_W'(1) : fh_reg;
        r_eff = (int'(rad_reg) > bmd_pkg::MAX_RADIUS) ? RAD_W'(bmd_pkg::MAX_RADIUS) : rad_reg;
    end

    // Output lag in pixels, and whether any pixel of the frame can be a seed
    assign lag      = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);
    assign seeds_ok = ((FH_W + 1)'(w_eff) >= (FH_W + 1)'({r_eff, 1'b1}))
                   && ((FH_W + 1)'(h_eff) >= (FH_W + 1)'({r_eff, 1'b1}));

    // Handshakes
    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign res_advance = !result_valid_reg || result_ready;
    assign s1_go       = s1_valid_reg && res_advance;
    assign pixel_ready = !s1_valid_reg || res_advance;
    assign pixel_fire  = pixel_valid && pixel_ready;

    // Frame position of the offered pixel
    assign h_row       = ROW_W'(h_eff);
    assign tail        = !start_reg && (in_row_reg >= h_row);
    assign frame_begin = start_reg || (tail && !is_flush);
    assign skip        = start_reg && is_flush;

    assign cur_row  = frame_begin ? '0 : in_row_reg;
    assign cur_col  = frame_begin ? '0 : in_col_reg;
    assign cur_win  = frame_begin ? '0 : win_reg;
    assign cur_lead = frame_begin ? '0 : lead_reg;
    assign cur_orow = frame_begin ? '0 : out_row_reg;
    assign cur_ocol = frame_begin ? '0 : out_col_reg;

    assign jx    = WC_W'(cur_col);
    assign rx    = WC_W'(r_eff);
    assign wx    = WC_W'(w_eff);
    assign r_row = ROW_W'(r_eff);

    // Seed test and horizontal window
    assign col_ge_r = (jx >= rx);
    assign seed     = !is_flush && (mask_byte == bmd_pkg::BYTE_W'(1))
                   && (cur_row >= r_row) && (cur_row + r_row < h_row)
                   && col_ge_r && (jx + rx < wx);
    assign win_new  = {cur_win[WIN_W-2:0], seed};

    always_comb
    begin
        for (int k = 0; k < WIN_W; k++)
        begin
            win_mask[k] = (k <= 2 * int'(r_eff));
        end
    end

    assign hit = |(win_new & win_mask);

    // Column update: the column radius pixels back, or at the start of a row
    // the trailing columns of the row before
    assign note_row = col_ge_r ? cur_row : cur_row - ROW_W'(1);
    assign note_en  = seeds_ok && !skip && (col_ge_r || (cur_row != '0));
    assign wr_col   = col_ge_r ? COL_W'(jx - rx) : COL_W'(jx + wx - rx);
    assign wr_en    = note_en && (hit || (note_row == '0));

    always_comb
    begin
        wr_entry.hit = hit;
        wr_entry.row = FH_W'(note_row);
    end

    // Result decision
    assign emit     = !skip && (cur_lead == lag);
    assign ocol_end = (WC_W'(cur_ocol) + WC_W'(1) >= wx);
    assign orow_end = ((FH_W + 1)'(cur_orow) + (FH_W + 1)'(1) >= (FH_W + 1)'(h_eff));
    assign last     = ocol_end && orow_end;
    assign col_end  = (jx + WC_W'(1) >= wx);
    assign fwd      = wr_en && (wr_col == cur_ocol);

    // Column hit memory
    bmd_ram #(
        .WIDTH (bmd_pkg::ENTRY_W),
        .DEPTH (bmd_pkg::MAX_WIDTH)
    ) u_gap_ram (
        .clk     (clk),
        .wr_en   (pixel_fire && wr_en),
        .wr_addr (wr_col),
        .wr_data (wr_entry),
        .rd_en   (pixel_fire && emit),
        .rd_addr (cur_ocol),
        .rd_data (rd_data)
    );

    // Next state of configuration and frame position
    always_comb
    begin
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        rad_next     = rad_reg;
        start_next   = start_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        lead_next    = lead_reg;
        win_next     = win_reg;

        // Advance on every pixel transaction that is not an idle flush
        if (pixel_fire && !skip)
        begin
            if (emit && last)
            begin
                start_next = 1'b1;
            end
            else
            begin
                start_next = 1'b0;
                win_next   = win_new;
                if (col_end)
                begin
                    in_col_next = '0;
                    in_row_next = cur_row + ROW_W'(1);
                end
                else
                begin
                    in_col_next = cur_col + COL_W'(1);
                    in_row_next = cur_row;
                end
                if (emit)
                begin
                    lead_next = cur_lead;
                    if (ocol_end)
                    begin
                        out_col_next = '0;
                        out_row_next = cur_orow + FH_W'(1);
                    end
                    else
                    begin
                        out_col_next = cur_ocol + COL_W'(1);
                        out_row_next = cur_orow;
                    end
                end
                else
                begin
                    lead_next    = cur_lead + LAG_W'(1);
                    out_col_next = cur_ocol;
                    out_row_next = cur_orow;
                end
            end
        end

        // Writes to the three configuration registers return the block to idle
        if (cfg_fire)
        begin
            case (cfg_index)
                bmd_pkg::CFG_FRAME_WIDTH:
                begin
                    fw_next    = cfg_data[FW_W-1:0];
                    start_next = 1'b1;
                end
                bmd_pkg::CFG_FRAME_HEIGHT:
                begin
                    fh_next    = cfg_data[FH_W-1:0];
                    start_next = 1'b1;
                end
                bmd_pkg::CFG_RADIUS:
                begin
                    rad_next   = cfg_data[RAD_W-1:0];
                    start_next = 1'b1;
                end
                default:
                begin
                    start_next = start_reg;
                end
            endcase
        end
    end

    // Stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pixel_fire && emit)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (s1_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg           <= bmd_pkg::RST_FRAME_WIDTH;
            fh_reg           <= bmd_pkg::RST_FRAME_HEIGHT;
            rad_reg          <= bmd_pkg::RST_RADIUS;
            start_reg        <= 1'b1;
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            lead_reg         <= '0;
            win_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            fw_reg           <= fw_next;
            fh_reg           <= fh_next;
            rad_reg          <= rad_next;
            start_reg        <= start_next;
            in_row_reg       <= in_row_next;
            in_col_reg       <= in_col_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            lead_reg         <= lead_next;
            win_reg          <= win_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the read stage payload alongside the memory read
    always_ff @(posedge clk)
    begin
        if (pixel_fire && emit)
        begin
            s1_orow_reg     <= cur_orow;
            s1_last_reg     <= last;
            s1_fwd_reg      <= fwd;
            s1_fwd_data_reg <= wr_entry;
        end
    end

    // Dilated pixel: a hit within radius rows of the output row
    assign rd_entry = bmd_pkg::gap_entry_t'(rd_data);
    assign s1_entry = s1_fwd_reg ? s1_fwd_data_reg : rd_entry;
    assign s1_bit   = seeds_ok && s1_entry.hit
                   && (ROW_W'(s1_entry.row) + r_row >= ROW_W'(s1_orow_reg));

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            dilated_bit_reg <= s1_bit;
            frame_last_reg  <= s1_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign dilated_bit  = dilated_bit_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

// ----- sv/bmd_ram.sv -----
// ----------------------------------------------------------------------------
// bmd_ram: generic simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- verif/binary_mask_dilation_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_dilation_core_tb: self-checking bench for the dilation core
// Streams raster masks through the pixel channel with random gaps and
// back-pressure. A behavioural shadow of the core predicts the dilated pixels
// that the script does not give itself, and each one is checked on arrival.
// Scripted corner cases run first, then sized extremes and random frames.
// ----------------------------------------------------------------------------

module binary_mask_dilation_core_tb;

    import bmd_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          ITEM_GOAL     = 1250;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 8;
    localparam int          HOLD_CYCLES   = 250;
    localparam int          GAP_MAX       = 17;
    localparam int          PIXEL_CAP     = 200;
    localparam int          DIRECTED_ROWS = 30;
    localparam logic [5:0]  GAP_FULL      = 6'd63;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL} row_kind_e;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} row_exp_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [IDX_W-1:0]   idx;
        logic [CFG_W-1:0]   data;
        logic [BYTE_W-1:0]  mask_v;
        logic               flush;
        row_exp_e           how;
        logic               want_bit;
        logic               want_last;
    } script_row_t;

    typedef struct packed {
        logic dilated;
        logic last;
    } dil_pixel_t;

    // Clock, reset and the block's inputs, all known from time zero
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                pixel_valid  = 1'b0;
    logic [BYTE_W-1:0]   mask_byte    = '0;
    logic                is_flush     = 1'b0;
    logic                result_ready = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic [IDX_W-1:0]    cfg_index    = '0;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                pixel_ready;
    logic                result_valid;
    logic                dilated_bit;
    logic                frame_last;

    // Shadow of the core: registers, column gaps, seed window, positions
    logic [FW_W-1:0]     reg_width;
    logic [FH_W-1:0]     reg_height;
    logic [RAD_W-1:0]    reg_radius;
    logic [5:0]          col_gap [MAX_WIDTH];
    logic [WIN_W-1:0]    seed_row;
    int unsigned         in_row, in_col, out_row, out_col;

    dil_pixel_t          pending_pixels [$];

    int unsigned         cycle_count   = 0;
    int unsigned         fail_count    = 0;
    int unsigned         pixels_sent   = 0;
    int unsigned         frame_items   = 0;
    int unsigned         results_seen  = 0;
    int unsigned         frames_closed = 0;
    int unsigned         settings_run  = 0;
    logic                tx_steady     = 1'b0;
    logic                hold_req      = 1'b0;

    script_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset sizes: nothing leaves for the first radius rows
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b1, EXP_NONE,  1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_CFG,   CFG_UNUSED,       16'hFFFF, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        // single pixel frames, no window: output is the seed itself
        '{ROW_CFG,   CFG_FRAME_WIDTH,  16'h0001, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_CFG,   CFG_FRAME_HEIGHT, 16'h0001, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_CFG,   CFG_RADIUS,       16'h0000, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b0, EXP_GIVEN, 1'b1, 1'b1},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_GIVEN, 1'b0, 1'b1},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, EXP_GIVEN, 1'b0, 1'b1},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'hFE, 1'b0, EXP_GIVEN, 1'b0, 1'b1},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b1, EXP_NONE,  1'b0, 1'b0},
        // zero sizes act as one
        '{ROW_CFG,   CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_CFG,   CFG_FRAME_HEIGHT, 16'h0000, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b0, EXP_GIVEN, 1'b1, 1'b1},
        // 3x3 frame, centre seed, flush as last pixel, pixel cutting the tail
        '{ROW_CFG,   CFG_FRAME_WIDTH,  16'h0003, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_CFG,   CFG_FRAME_HEIGHT, 16'h0003, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_CFG,   CFG_RADIUS,       16'h0001, 8'h00, 1'b0, EXP_NONE,  1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b1, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b1, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b1, EXP_MODEL, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b0, EXP_MODEL, 1'b0, 1'b0}
    };

    binary_mask_dilation_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .mask_byte    (mask_byte),
        .is_flush     (is_flush),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .dilated_bit  (dilated_bit),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    logic cfg_ready;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the core
    // ------------------------------------------------------------------

    // Effective sizes after clamping the raw register values
    function automatic int unsigned span_w();
        if (reg_width == '0) return 1;
        if (reg_width > MAX_WIDTH) return MAX_WIDTH;
        return reg_width;
    endfunction

    function automatic int unsigned span_h();
        return (reg_height == '0) ? 1 : reg_height;
    endfunction

    function automatic int unsigned span_r();
        return (reg_radius > MAX_RADIUS) ? MAX_RADIUS : reg_radius;
    endfunction

    function automatic logic [WIN_W-1:0] near_bits(input int unsigned n);
        logic [63:0] m;
        m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        return m[WIN_W-1:0];
    endfunction

    function automatic void frame_idle();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic void dilation_reset_state();
        reg_width  = RST_FRAME_WIDTH;
        reg_height = RST_FRAME_HEIGHT;
        reg_radius = RST_RADIUS;
        foreach (col_gap[c]) col_gap[c] = GAP_FULL;
        seed_row = '0;
        frame_idle();
    endfunction

    // A register write lands at once and parks the core at frame start
    function automatic void mask_reg_write(input logic [IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] val);
        case (idx)
            CFG_FRAME_WIDTH:  reg_width  = val[FW_W-1:0];
            CFG_FRAME_HEIGHT: reg_height = val[FH_W-1:0];
            CFG_RADIUS:       reg_radius = val[RAD_W-1:0];
            default:          return;
        endcase
        frame_idle();
    endfunction

    // Reset the gap count on a hit, otherwise age it up to saturation
    function automatic void note_gap(input int unsigned c, input logic hit);
        if (hit) col_gap[c] = '0;
        else if (col_gap[c] != GAP_FULL) col_gap[c] = col_gap[c] + 6'd1;
    endfunction

    // Advance the shadow by one pixel transaction; returns 1 when a pixel leaves
    function automatic bit dilate_pixel(input logic [BYTE_W-1:0] mv, input logic fl,
                                        output dil_pixel_t px);
        int unsigned w, h, r, i, j, c, pos, lag;
        logic        seed;
        w  = span_w();
        h  = span_h();
        r  = span_r();
        px = '0;
        // a real pixel after the frame drops the undrained tail
        if (!fl && in_row >= h) frame_idle();
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (in_row == 0 && in_col == 0) begin
            if (fl) return 1'b0;
            foreach (col_gap[k]) col_gap[k] = GAP_FULL;
            out_row = 0;
            out_col = 0;
        end
        i = in_row;
        j = in_col;
        if (j == 0) seed_row = '0;
        seed = !fl && mv == 8'd1 && i >= r && i + r < h && j >= r && j + r < w;
        seed_row = {seed_row[WIN_W-2:0], seed};
        if (j >= r) note_gap(j - r, |(seed_row & near_bits(2 * r + 1)));
        // close the columns near the right edge at the end of a row
        if (j + 1 >= w)
            for (c = (w > r) ? w - r : 0; c < w; c++)
                note_gap(c, |(seed_row & near_bits(w - c + r)));
        pos = i * w + j;
        lag = r * w + r;
        if (pos >= lag) begin
            px.dilated = col_gap[out_col] <= 2 * r;
            px.last    = (out_row + 1 >= h) && (out_col + 1 >= w);
            if (px.last) begin
                frame_idle();
                return 1'b1;
            end
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        end
        if (j + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col = j + 1;
        end
        return pos >= lag;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one pixel transaction and record what should come out of it
    task automatic send_item(input logic [BYTE_W-1:0] mv, input logic fl,
                             input row_exp_e how, input logic gb, input logic gl);
        int unsigned gap;
        dil_pixel_t  px;
        bit          made;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) @(negedge clk) pixel_valid <= 1'b0;
        @(negedge clk);
        pixel_valid <= 1'b1;
        mask_byte   <= mv;
        is_flush    <= fl;
        do @(posedge clk); while (!pixel_ready);
        pixels_sent++;
        made = dilate_pixel(mv, fl, px);
        if (how == EXP_MODEL && made) pending_pixels.push_back(px);
        if (how == EXP_GIVEN) begin
            px.dilated = gb;
            px.last    = gl;
            pending_pixels.push_back(px);
        end
    endtask

    // Hold the sender until every expected pixel has been taken
    task automatic drain_results();
        @(negedge clk) pixel_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        mask_reg_write(idx, val);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] draw_mask(input int unsigned dens);
        int unsigned ones_per_32 [4] = '{1, 4, 16, 28};
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return ($urandom_range(0, 31) < ones_per_32[dens]) ? 8'd1 : 8'd0;
    endfunction

    // Program all three registers, then stream frames; uncapped ones get a flush tail
    task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                             input logic [CFG_W-1:0] r_raw, input int unsigned frames,
                             input int unsigned cap, input logic steady);
        logic [IDX_W-1:0] reg_idx [3];
        logic [CFG_W-1:0] reg_val [3];
        int unsigned      rot, k, f, w, h, r, lag, npix, nflush, dens, pause_at;
        logic             partial;
        reg_idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_RADIUS};
        reg_val = '{w_raw, h_raw, r_raw};
        rot = $urandom_range(0, 2);
        for (k = 0; k < 3; k++) write_reg(reg_idx[(k + rot) % 3], reg_val[(k + rot) % 3]);
        settings_run++;
        w   = span_w();
        h   = span_h();
        r   = span_r();
        lag = r * w + r;
        npix    = w * h;
        partial = npix > cap;
        if (partial) npix = cap;
        for (f = 0; f < frames; f++) begin
            tx_steady = steady || ($urandom_range(0, 3) == 0);
            dens      = $urandom_range(0, 3);
            pause_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, npix - 1) : npix;
            for (k = 0; k < npix; k++) begin
                if (k == pause_at) drain_results();
                send_item(draw_mask(dens), $urandom_range(0, 19) == 0, EXP_MODEL, 1'b0, 1'b0);
                frame_items++;
            end
            if (partial) break;
            // drain the tail: sometimes cut short, sometimes overshoot into idle
            nflush = lag;
            case ($urandom_range(0, 5))
                0:       nflush = $urandom_range(0, lag);
                1:       nflush = lag + $urandom_range(1, 3);
                default: nflush = lag;
            endcase
            for (k = 0; k < nflush; k++) begin
                send_item($urandom_range(0, 255), 1'b1, EXP_MODEL, 1'b0, 1'b0);
                if (k < lag) frame_items++;
            end
        end
        tx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, checking
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        logic        rx_steady;
        dil_pixel_t  want;
        rx_steady = 1'b0;
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            end
            repeat (stall) @(negedge clk) result_ready <= 1'b0;
            @(negedge clk) result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            results_seen++;
            if (frame_last) frames_closed++;
            if (pending_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: dilated_bit=%0b frame_last=%0b",
                             dilated_bit, frame_last);
            end else begin
                want = pending_pixels.pop_front();
                if (dilated_bit !== want.dilated || frame_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d: expected dilated_bit=%0b frame_last=%0b, got %0b %0b",
                                 results_seen, want.dilated, want.last, dilated_bit, frame_last);
                end
            end
            if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        end
    end

    // Abandon a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned      n, goal_base;
        logic [CFG_W-1:0] w_raw, h_raw, r_raw;
        dilation_reset_state();
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // scripted corner cases
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            if (directed_rows[n].kind == ROW_CFG)
                write_reg(directed_rows[n].idx, directed_rows[n].data);
            else
                send_item(directed_rows[n].mask_v, directed_rows[n].flush,
                          directed_rows[n].how, directed_rows[n].want_bit,
                          directed_rows[n].want_last);
        end

        // widest row (over-range width clamps), tallest frame, oversized radius
        run_phase(16'h07FF, 16'd1, 16'd0, 1, MAX_WIDTH + 8, 1'b0);
        run_phase(16'd8, 16'hFFFF, 16'd3, 1, 120, 1'b0);
        run_phase(16'd4, 16'd4, 16'hFFFF, 2, PIXEL_CAP, 1'b0);

        // long receiver hold-off against a back-to-back sender
        hold_req = 1'b1;
        run_phase(16'd6, 16'd6, 16'd0, 1, PIXEL_CAP, 1'b1);

        // random sizes, mostly small
        goal_base = frame_items;
        while (frame_items - goal_base < ITEM_GOAL) begin
            w_raw = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            h_raw = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            r_raw = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3))
                                                : 16'($urandom_range(4, 15));
            if ($urandom_range(0, 3) == 0) w_raw[CFG_W-1:FW_W] = $urandom_range(0, 31);
            if ($urandom_range(0, 3) == 0) r_raw[CFG_W-1:RAD_W] = $urandom_range(0, 4095);
            run_phase(w_raw, h_raw, r_raw, $urandom_range(1, 3), PIXEL_CAP, 1'b0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d pixel transactions over %0d register settings in %0d cycles.",
                 pixels_sent, settings_run, cycle_count);
        $display("Checked %0d dilated pixels, %0d frame ends, %0d failures.",
                 results_seen, frames_closed, fail_count);
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
